// ===== sv/djs_pkg.sv =====
// Shared constants, state types and command struct for the deadline job scheduler.
package djs_pkg;

	localparam int MAX_JOBS_DEF = 1024;
	localparam int DEADLINE_BITS_DEF = 10;
	localparam int SCORE_BITS_DEF = 16;
	localparam int TOTAL_BITS = 26;

	typedef struct packed {
		logic start;
		logic pop;
		logic clear;
	} heap_cmd_t;

	typedef enum logic [2:0] {
		HP_IDLE,
		HP_PUSH_RD,
		HP_PUSH_CMP,
		HP_POP_LD,
		HP_POP_RD,
		HP_POP_CMP
	} heap_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_STORE,
		T_RUN,
		T_WJOB,
		T_WKEPT,
		T_WDROP,
		T_DONE
	} top_state_t;

endpackage

// ===== sv/djs_heap.sv =====
// Iterative min-heap with push, pop and clear; each sift level takes a read and a compare state.
module djs_heap import djs_pkg::*; #(
	parameter int DEPTH = MAX_JOBS_DEF,
	parameter int WIDTH = DEADLINE_BITS_DEF + SCORE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  heap_cmd_t                   cmd,
	input  logic [WIDTH-1:0]            wdata,
	output logic                        busy,
	output logic [$clog2(DEPTH):0]      count,
	output logic [WIDTH-1:0]            top
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 2;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd0_q, rd1_q, val_q, top_q;
	logic [AW-1:0]    idx_q, idx_d, ra0, ra1, wa;
	logic [AW:0]      cnt_q, cnt_d;
	logic [WIDTH-1:0] val_d, top_d, wd;
	logic             we;
	heap_state_t      state_q, state_d;
	logic [CW-1:0]    child, child1;
	logic [AW-1:0]    parent, cnt_m1;
	logic             take_right;
	logic [WIDTH-1:0] cmin;
	logic [AW-1:0]    cmin_idx;

	assign child = {1'b0, idx_q, 1'b0} + CW'(1);
	assign child1 = child + CW'(1);
	assign parent = (idx_q - AW'(1)) >> 1;
	assign cnt_m1 = AW'(cnt_q - (AW+1)'(1));
	assign take_right = (child1 < CW'(cnt_q)) && (rd1_q < rd0_q);
	assign cmin = take_right ? rd1_q : rd0_q;
	assign cmin_idx = take_right ? child1[AW-1:0] : child[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
		val_q <= val_d;
		top_q <= top_d;
		idx_q <= idx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HP_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		val_d = val_q;
		top_d = top_q;
		ra0 = '0;
		ra1 = '0;
		wa = idx_q;
		wd = val_q;
		we = 1'b0;
		unique case (state_q)
			HP_IDLE: begin
				if (cmd.clear) begin
					cnt_d = '0;
				end else if (cmd.start && cmd.pop) begin
					cnt_d = cnt_q - (AW+1)'(1);
					ra1 = cnt_m1;
					state_d = HP_POP_LD;
				end else if (cmd.start) begin
					idx_d = AW'(cnt_q);
					cnt_d = cnt_q + (AW+1)'(1);
					val_d = wdata;
					state_d = HP_PUSH_RD;
				end
			end
			HP_PUSH_RD: begin
				if (idx_q == '0) begin
					we = 1'b1;
					state_d = HP_IDLE;
				end else begin
					ra0 = parent;
					state_d = HP_PUSH_CMP;
				end
			end
			HP_PUSH_CMP: begin
				if (rd0_q <= val_q) begin
					we = 1'b1;
					state_d = HP_IDLE;
				end else begin
					we = 1'b1;
					wd = rd0_q;
					idx_d = parent;
					state_d = HP_PUSH_RD;
				end
			end
			HP_POP_LD: begin
				top_d = rd0_q;
				val_d = rd1_q;
				idx_d = '0;
				state_d = HP_POP_RD;
			end
			HP_POP_RD: begin
				if (child >= CW'(cnt_q)) begin
					we = (cnt_q != '0);
					state_d = HP_IDLE;
				end else begin
					ra0 = child[AW-1:0];
					ra1 = child1[AW-1:0];
					state_d = HP_POP_CMP;
				end
			end
			HP_POP_CMP: begin
				if (val_q <= cmin) begin
					we = 1'b1;
					state_d = HP_IDLE;
				end else begin
					we = 1'b1;
					wd = cmin;
					idx_d = cmin_idx;
					state_d = HP_POP_RD;
				end
			end
			default: state_d = HP_IDLE;
		endcase
	end

	assign busy = (state_q != HP_IDLE);
	assign count = cnt_q;
	assign top = top_q;

endmodule

// ===== sv/deadline_job_scheduler_top.sv =====
// Top level: job store heap, kept-score heap and the greedy sequencer.
//
//  channel | signals                          | direction
//  in      | valid ready deadline score last  | job beat into the block
//  out     | out_valid out_ready total_score  | one result beat per job set
//
// A stored job rises one heap level per read state and compare state, up to about log2(MAX_JOBS) levels.
// After the last job, each job costs one pop of the job heap, one push of the kept heap
// and possibly one pop of it, each a read and a compare state per level on one read port pair.
// Reset empties both heaps and the total. A waiting result does not block new jobs;
// a new result waits until the previous one is taken.
module deadline_job_scheduler_top import djs_pkg::*; #(
	parameter int MAX_JOBS = MAX_JOBS_DEF,
	parameter int DEADLINE_BITS = DEADLINE_BITS_DEF,
	parameter int SCORE_BITS = SCORE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	output logic                     ready,
	input  logic [DEADLINE_BITS-1:0] deadline,
	input  logic [SCORE_BITS-1:0]    score,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [TOTAL_BITS-1:0]    total_score
);

	localparam int KW = DEADLINE_BITS + SCORE_BITS;
	localparam int AW = $clog2(MAX_JOBS);
	localparam int SW = (TOTAL_BITS > SCORE_BITS) ? TOTAL_BITS : SCORE_BITS;
	localparam int CMPW = ((AW + 1) > DEADLINE_BITS) ? (AW + 1) : DEADLINE_BITS;

	top_state_t state_q, state_d;
	heap_cmd_t  job_cmd, kept_cmd;
	logic       job_busy, kept_busy;
	logic [AW:0] job_cnt, kept_cnt;
	logic [KW-1:0] job_top;
	logic [SCORE_BITS-1:0] kept_top, sc_q, sc_d;
	logic [DEADLINE_BITS-1:0] dl_q, dl_d;
	logic [TOTAL_BITS-1:0] total_q, total_d, res_q, res_d;
	logic last_q, last_d, ov_q, ov_d;
	logic [SW-1:0] sum_w, dif_w;

	djs_heap #(.DEPTH(MAX_JOBS), .WIDTH(KW)) u_jobs (
		.clk(clk), .arst_n(arst_n), .cmd(job_cmd), .wdata({deadline, score}),
		.busy(job_busy), .count(job_cnt), .top(job_top)
	);

	djs_heap #(.DEPTH(MAX_JOBS), .WIDTH(SCORE_BITS)) u_kept (
		.clk(clk), .arst_n(arst_n), .cmd(kept_cmd), .wdata(sc_q),
		.busy(kept_busy), .count(kept_cnt), .top(kept_top)
	);

	assign sum_w = SW'(total_q) + SW'(sc_q);
	assign dif_w = SW'(total_q) - SW'(kept_top);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			total_q <= '0;
			last_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			last_q <= last_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		sc_q <= sc_d;
		dl_q <= dl_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		total_d = total_q;
		last_d = last_q;
		ov_d = ov_q && !out_ready;
		sc_d = sc_q;
		dl_d = dl_q;
		res_d = res_q;
		job_cmd = '0;
		kept_cmd = '0;
		ready = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				ready = 1'b1;
				if (valid) begin
					last_d = last;
					if (job_cnt != (AW+1)'(MAX_JOBS)) begin
						job_cmd.start = 1'b1;
						state_d = T_STORE;
					end else if (last) begin
						state_d = T_RUN;
					end
				end
			end
			T_STORE: begin
				if (!job_busy) begin
					state_d = last_q ? T_RUN : T_IDLE;
				end
			end
			T_RUN: begin
				if (job_cnt == '0) begin
					state_d = T_DONE;
				end else begin
					job_cmd.start = 1'b1;
					job_cmd.pop = 1'b1;
					state_d = T_WJOB;
				end
			end
			T_WJOB: begin
				if (!job_busy) begin
					sc_d = job_top[SCORE_BITS-1:0];
					dl_d = job_top[KW-1:SCORE_BITS];
					state_d = T_WKEPT;
				end
			end
			T_WKEPT: begin
				// The push is issued here and the total grows by the same score at once.
				if (!kept_busy) begin
					kept_cmd.start = 1'b1;
					total_d = sum_w[TOTAL_BITS-1:0];
					state_d = T_WDROP;
					last_d = 1'b0;
				end
			end
			T_WDROP: begin
				if (!kept_busy && !last_q) begin
					if (CMPW'(kept_cnt) > CMPW'(dl_q)) begin
						kept_cmd.start = 1'b1;
						kept_cmd.pop = 1'b1;
						last_d = 1'b1;
					end else begin
						state_d = T_RUN;
					end
				end else if (!kept_busy) begin
					total_d = dif_w[TOTAL_BITS-1:0];
					last_d = 1'b0;
					state_d = T_RUN;
				end
			end
			T_DONE: begin
				if (!ov_q) begin
					res_d = total_q;
					ov_d = 1'b1;
					total_d = '0;
					last_d = 1'b0;
					kept_cmd.clear = 1'b1;
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	assign out_valid = ov_q;
	assign total_score = res_q;

endmodule

// ===== sim/deadline_job_scheduler_checker.sv =====
// Checker: watches both channels, predicts the greedy deadline schedule and compares totals.
module deadline_job_scheduler_checker import djs_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  logic                         ready,
	input  logic [DEADLINE_BITS_DEF-1:0] deadline,
	input  logic [SCORE_BITS_DEF-1:0]    score,
	input  logic                         last,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [TOTAL_BITS-1:0]        total_score,
	output int                           fail_count,
	output int                           pending_totals
);

	typedef struct packed {
		logic [DEADLINE_BITS_DEF-1:0] dl;
		logic [SCORE_BITS_DEF-1:0]    sc;
	} job_t;

	job_t                     job_set[$];
	logic [TOTAL_BITS-1:0]    expected_totals[$];

	// Greedy schedule: jobs by (deadline, score) ascending, keep the best scores
	// that fit, dropping the smallest kept score whenever the kept count exceeds
	// the current deadline.
	function automatic logic [TOTAL_BITS-1:0] best_total(input job_t jobs[$]);
		job_t    sorted[$];
		int      kept[$];
		longint  sum;
		sorted = jobs;
		sorted.sort() with ({item.dl, item.sc});
		sum = 0;
		foreach (sorted[i]) begin
			kept.push_back(sorted[i].sc);
			sum += sorted[i].sc;
			if (kept.size() > sorted[i].dl) begin
				kept.sort();
				sum -= kept.pop_front();
			end
		end
		return sum[TOTAL_BITS-1:0];
	endfunction

	always_comb pending_totals = expected_totals.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			job_set.delete();
			expected_totals.delete();
		end else begin
			if (valid && ready) begin
				if (job_set.size() < MAX_JOBS_DEF)
					job_set.push_back('{deadline, score});
				if (last) begin
					expected_totals.push_back(best_total(job_set));
					job_set.delete();
				end
			end
			if (out_valid && out_ready) begin
				if (expected_totals.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected total beat: got %0d", total_score);
				end else begin
					if (total_score !== expected_totals[0]) begin
						fail_count++;
						if (fail_count <= 10)
							$display("total_score mismatch: expected %0d got %0d",
								expected_totals[0], total_score);
					end
					void'(expected_totals.pop_front());
				end
			end
		end
	end

endmodule

// ===== sim/tb_deadline_job_scheduler_top.sv =====
// Testbench top: drives job sets and result back-pressure, then gives the verdict.
module tb_deadline_job_scheduler_top;
	import djs_pkg::*;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         valid = 1'b0;
	logic                         ready;
	logic [DEADLINE_BITS_DEF-1:0] deadline = '0;
	logic [SCORE_BITS_DEF-1:0]    score = '0;
	logic                         last = 1'b0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [TOTAL_BITS-1:0]        total_score;
	int                           fail_count;
	int                           pending_totals;
	int                           cycle_count = 0;
	bit                           calm_phase = 1'b0;
	bit                           hold_outputs = 1'b0;
	bit                           long_hold_done = 1'b0;

	always #5 clk = ~clk;

	deadline_job_scheduler_top u_top (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.deadline(deadline), .score(score), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .total_score(total_score)
	);

	deadline_job_scheduler_checker u_checker (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.deadline(deadline), .score(score), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .total_score(total_score),
		.fail_count(fail_count), .pending_totals(pending_totals)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold that lets the
	// block back up onto its job input.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_outputs) begin
				out_ready <= 1'b0;
				repeat (3000) @(negedge clk);
				hold_outputs = 1'b0;
				long_hold_done = 1'b1;
			end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Valid stays high from one beat to the next unless an idle burst comes between.
	task automatic send_job(input int dl, input int sc, input bit fin);
		if (!calm_phase && $urandom_range(0, 4) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		valid <= 1'b1;
		deadline <= DEADLINE_BITS_DEF'(dl);
		score <= SCORE_BITS_DEF'(sc);
		last <= fin;
		@(posedge clk);
		while (!ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_set(input int jobs, input int dl_max);
		for (int i = 0; i < jobs; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_job($urandom_range(0, 1023), $urandom_range(0, 65535), i == jobs - 1);
			else
				send_job($urandom_range(0, dl_max), $urandom_range(0, 65535), i == jobs - 1);
		end
	endtask

	initial begin
		int sent;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: single jobs at the field extremes and a zero deadline.
		send_job(0, 65535, 1'b1);
		send_job(1023, 65535, 1'b1);
		send_job(1, 0, 1'b1);
		send_job(1023, 0, 1'b1);
		// Contention on one slot: only the best deadline-1 score survives, the deadline-0 job is dropped.
		send_job(1, 10, 1'b0);
		send_job(1, 30, 1'b0);
		send_job(1, 20, 1'b0);
		send_job(0, 500, 1'b1);
		// Equal deadlines and scores, and alternating bit patterns.
		send_job(2, 7, 1'b0);
		send_job(2, 7, 1'b0);
		send_job(2, 7, 1'b1);
		send_job(10'h2AA, 16'hAAAA, 1'b0);
		send_job(10'h155, 16'h5555, 1'b0);
		send_job(3, 65535, 1'b0);
		send_job(3, 65534, 1'b1);
		// Sender pauses until every expected total has arrived.
		valid <= 1'b0;
		while (pending_totals != 0) @(negedge clk);

		// Random sets, mostly small with tight deadlines so drops happen.
		sent = 0;
		while (sent < 60) begin
			int n;
			n = $urandom_range(1, 12);
			send_random_set(n, $urandom_range(0, 8));
			sent += n;
			if (sent > 20 && !long_hold_done && !hold_outputs)
				hold_outputs = 1'b1;
		end
		while (!long_hold_done) begin
			send_random_set($urandom_range(1, 3), 4);
			sent++;
		end

		// One set that overfills the job store; extra jobs are dropped.
		send_random_set(1030, 600);

		calm_phase = 1'b1;
		for (int k = 0; k < 10; k++)
			send_random_set($urandom_range(1, 8), $urandom_range(0, 6));

		valid <= 1'b0;
		while (pending_totals != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
sv/djs_pkg.sv
sv/djs_heap.sv
sv/deadline_job_scheduler_top.sv
sim/deadline_job_scheduler_checker.sv
sim/tb_deadline_job_scheduler_top.sv
